>>> hdl/asfr_pkg.sv
// Shared types and constants for the addressed serial frame receiver.
package asfr_pkg;

    // Frame format
    localparam logic [7:0]  START_BYTE     = 8'h3A;
    localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
    localparam logic [15:0] HEADER_LEN     = 16'd5;
    // Header bytes kept in the store: address, function, subfunction, length low
    localparam int          HDR_KEEP       = 4;
    localparam int          HDR_IDX_W      = $clog2(HDR_KEEP);

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kind codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // Configuration register map
    localparam int              CFG_INDEX_W       = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [7:0]      NODE_ADDRESS_RST  = 8'd2;
    localparam logic [7:0]      TIMEOUT_TICKS_RST = 8'd3;

    // Parser phase
    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_HEADER  = 2'd1,
        PHASE_PAYLOAD = 2'd2
    } phase_t;

endpackage

>>> hdl/addressed_serial_frame_receiver.sv
// Top level of the addressed serial frame receiver: parser, tick timeout and result register.
//
// Each transfer on the s_ channel is either a received byte or a timer tick. The parser,
// the header store and the tick counter update at the edge that takes the transfer, and
// any result (a payload byte with its index, or a frame-complete record with the header
// fields) appears in the m_ output register on the next cycle. Throughput is one item per
// clock: s_ready is high whenever the output register is empty or is being drained in the
// same cycle, so only a stalled m_ready holds the input back. Ticks never produce a result.
// The cfg_ channel is always ready; write it only while no frame is in progress.
module addressed_serial_frame_receiver (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [7:0]                      s_rx_byte,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [7:0]                      m_dest_address,
    output logic [7:0]                      m_function_code,
    output logic [7:0]                      m_subfunction_code,
    output logic [15:0]                     m_payload_length,
    output logic [15:0]                     m_payload_index,
    output logic [7:0]                      m_payload_byte,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    // Configuration registers
    logic [7:0] node_address_reg;
    logic [7:0] timeout_ticks_reg;

    // Parser state
    asfr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [15:0] expected_length_reg, expected_length_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [7:0]  hdr_reg [asfr_pkg::HDR_KEEP];
    logic        hdr_we;
    logic [7:0]  tick_inc;

    // Result computed for the current transfer
    logic        res_valid;
    logic        res_kind;
    logic [15:0] res_index;
    logic [7:0]  res_byte;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg;
    logic [7:0]  m_dest_address_reg;
    logic [7:0]  m_function_code_reg;
    logic [7:0]  m_subfunction_code_reg;
    logic [15:0] m_payload_length_reg;
    logic [15:0] m_payload_index_reg;
    logic [7:0]  m_payload_byte_reg;

    logic        s_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg  <= asfr_pkg::NODE_ADDRESS_RST;
            timeout_ticks_reg <= asfr_pkg::TIMEOUT_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == asfr_pkg::REG_NODE_ADDRESS) begin
                node_address_reg <= cfg_data;
            end else if (cfg_index == asfr_pkg::REG_TIMEOUT_TICKS) begin
                timeout_ticks_reg <= cfg_data;
            end
        end
    end

    // Compute next parser state and the result for one transfer
    always_comb begin
        phase_next           = phase_reg;
        byte_index_next      = byte_index_reg;
        expected_length_next = expected_length_reg;
        tick_count_next      = tick_count_reg;
        hdr_we               = 1'b0;
        res_valid            = 1'b0;
        res_kind             = asfr_pkg::KIND_PAYLOAD;
        res_index            = 16'd0;
        res_byte             = 8'd0;
        tick_inc             = tick_count_reg + 8'd1;

        if (s_cmd == asfr_pkg::CMD_TICK) begin
            // Count ticks; force idle on expiry
            tick_count_next = tick_inc;
            if (tick_inc == timeout_ticks_reg) begin
                tick_count_next = 8'd0;
                phase_next      = asfr_pkg::PHASE_IDLE;
                byte_index_next = 16'd0;
            end
        end else begin
            case (phase_reg)
                asfr_pkg::PHASE_IDLE: begin
                    if (s_rx_byte == asfr_pkg::START_BYTE) begin
                        phase_next      = asfr_pkg::PHASE_HEADER;
                        byte_index_next = 16'd0;
                    end
                end
                asfr_pkg::PHASE_HEADER: begin
                    // Skip start bytes inside the header
                    if (s_rx_byte != asfr_pkg::START_BYTE &&
                        byte_index_reg < asfr_pkg::HEADER_LEN) begin
                        byte_index_next = byte_index_reg + 16'd1;
                        if (byte_index_reg < 16'(asfr_pkg::HDR_KEEP)) begin
                            hdr_we = 1'b1;
                        end
                        // Last header byte: check the address and latch the length
                        if (byte_index_next == asfr_pkg::HEADER_LEN) begin
                            byte_index_next = 16'd0;
                            if (hdr_reg[0] == node_address_reg ||
                                hdr_reg[0] == asfr_pkg::BROADCAST_ADDR) begin
                                expected_length_next = {s_rx_byte, hdr_reg[3]};
                                phase_next           = asfr_pkg::PHASE_PAYLOAD;
                            end else begin
                                phase_next = asfr_pkg::PHASE_IDLE;
                            end
                        end
                    end
                end
                asfr_pkg::PHASE_PAYLOAD: begin
                    if (byte_index_reg < expected_length_reg) begin
                        res_valid       = 1'b1;
                        res_kind        = asfr_pkg::KIND_PAYLOAD;
                        res_index       = byte_index_reg;
                        res_byte        = s_rx_byte;
                        byte_index_next = byte_index_reg + 16'd1;
                    end else begin
                        // This byte ends the frame and is consumed by it
                        res_valid  = 1'b1;
                        res_kind   = asfr_pkg::KIND_DONE;
                        phase_next = asfr_pkg::PHASE_IDLE;
                    end
                end
                default: begin
                    // Unused phase code: drop the byte
                end
            endcase
        end
    end

    // Advance parser state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= asfr_pkg::PHASE_IDLE;
            byte_index_reg      <= 16'd0;
            expected_length_reg <= 16'd0;
            tick_count_reg      <= 8'd0;
        end else if (s_xfer) begin
            phase_reg           <= phase_next;
            byte_index_reg      <= byte_index_next;
            expected_length_reg <= expected_length_next;
            tick_count_reg      <= tick_count_next;
        end
    end

    // Write header bytes into the store
    always_ff @(posedge aclk) begin
        if (s_xfer && hdr_we) begin
            hdr_reg[byte_index_reg[asfr_pkg::HDR_IDX_W-1:0]] <= s_rx_byte;
        end
    end

    // Load or drain the output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_ready) begin
            m_valid_next = s_valid && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && res_valid) begin
            m_kind_reg             <= res_kind;
            m_dest_address_reg     <= hdr_reg[0];
            m_function_code_reg    <= hdr_reg[1];
            m_subfunction_code_reg <= hdr_reg[2];
            m_payload_length_reg   <= expected_length_reg;
            m_payload_index_reg    <= res_index;
            m_payload_byte_reg     <= res_byte;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = m_kind_reg;
    assign m_dest_address     = m_dest_address_reg;
    assign m_function_code    = m_function_code_reg;
    assign m_subfunction_code = m_subfunction_code_reg;
    assign m_payload_length   = m_payload_length_reg;
    assign m_payload_index    = m_payload_index_reg;
    assign m_payload_byte     = m_payload_byte_reg;

endmodule

>>> hdl/asfr_checker.sv
// Port-level assertions for the addressed serial frame receiver, with their bind.
module asfr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_cmd,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_kind,
    input logic [7:0]                      m_dest_address,
    input logic [7:0]                      m_function_code,
    input logic [7:0]                      m_subfunction_code,
    input logic [15:0]                     m_payload_length,
    input logic [15:0]                     m_payload_index,
    input logic [7:0]                      m_payload_byte
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_payload_index) &&
        $stable(m_payload_byte) && $stable(m_payload_length) && $stable(m_dest_address) &&
        $stable(m_function_code) && $stable(m_subfunction_code))
        else $error("stalled result changed");

    // Take input whenever the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // Ticks produce no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == asfr_pkg::CMD_TICK |=> !m_valid)
        else $error("tick transfer produced a result");

    // Frame-complete results carry zero index and byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == asfr_pkg::KIND_DONE |->
        m_payload_index == 16'd0 && m_payload_byte == 8'd0)
        else $error("completion result with payload data");

    // Payload index stays below the declared length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == asfr_pkg::KIND_PAYLOAD |-> m_payload_index < m_payload_length)
        else $error("payload index beyond declared length");

endmodule

bind addressed_serial_frame_receiver asfr_checker u_asfr_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the addressed serial frame receiver.
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int TOTAL_ITEMS  = 450;
    localparam int NUM_PHASES   = 5;

    typedef struct packed {
        logic        kind;
        logic [7:0]  dest_address;
        logic [7:0]  function_code;
        logic [7:0]  subfunction_code;
        logic [15:0] payload_length;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
    } frame_record_t;

    typedef struct packed {
        logic          cmd;
        logic [7:0]    rx;
        logic          typed;
        frame_record_t want;
    } stim_row_t;

    localparam frame_record_t NO_RECORD = '0;
    localparam int NUM_ROWS = 29;

    // Directed table: broadcast frame with skipped start byte and 0x3A payload,
    // zero-length frame to the node, foreign address, tick timeout mid-header
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'hFF, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'hFF, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h02, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b1,
          '{asfr_pkg::KIND_PAYLOAD, 8'hFF, 8'h00, 8'hFF, 16'd2, 16'd0, 8'h3A}},
        '{asfr_pkg::CMD_BYTE, 8'hFF, 1'b1,
          '{asfr_pkg::KIND_PAYLOAD, 8'hFF, 8'h00, 8'hFF, 16'd2, 16'd1, 8'hFF}},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b1,
          '{asfr_pkg::KIND_DONE, 8'hFF, 8'h00, 8'hFF, 16'd2, 16'd0, 8'h00}},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h02, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'hA5, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h5A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h55, 1'b1,
          '{asfr_pkg::KIND_DONE, 8'h02, 8'hA5, 8'h5A, 16'd0, 16'd0, 8'h00}},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h07, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h01, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h02, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h03, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h04, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h3A, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'hFF, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_TICK, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_TICK, 8'hFF, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_TICK, 8'h00, 1'b0, NO_RECORD},
        '{asfr_pkg::CMD_BYTE, 8'h11, 1'b0, NO_RECORD}
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    logic                             s_cmd     = 1'b0;
    logic [7:0]                       s_rx_byte = 8'h00;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    logic                             m_kind;
    logic [7:0]                       m_dest_address;
    logic [7:0]                       m_function_code;
    logic [7:0]                       m_subfunction_code;
    logic [15:0]                      m_payload_length;
    logic [15:0]                      m_payload_index;
    logic [7:0]                       m_payload_byte;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [asfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                       cfg_data  = 8'h00;

    // Parser mirror and its copy of the registers
    asfr_pkg::phase_t rx_phase = asfr_pkg::PHASE_IDLE;
    logic [15:0] rx_count     = '0;
    logic [7:0]  hdr_bytes [5] = '{default: 8'h00};
    logic [15:0] declared_len = '0;
    logic [7:0]  tick_total   = '0;
    logic [7:0]  node_addr_reg = asfr_pkg::NODE_ADDRESS_RST;
    logic [7:0]  timeout_reg   = asfr_pkg::TIMEOUT_TICKS_RST;

    frame_record_t pending_records [$];
    int errors       = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int ready_run    = 0;
    int stall_run    = 0;
    int quiet_cycles = 0;

    addressed_serial_frame_receiver uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_dest_address     (m_dest_address),
        .m_function_code    (m_function_code),
        .m_subfunction_code (m_subfunction_code),
        .m_payload_length   (m_payload_length),
        .m_payload_index    (m_payload_index),
        .m_payload_byte     (m_payload_byte),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic frame_record_t frame_fields(input logic kind, input logic [15:0] idx,
                                                   input logic [7:0] val);
        frame_record_t rec;
        rec.kind             = kind;
        rec.dest_address     = hdr_bytes[0];
        rec.function_code    = hdr_bytes[1];
        rec.subfunction_code = hdr_bytes[2];
        rec.payload_length   = declared_len;
        rec.payload_index    = idx;
        rec.payload_byte     = val;
        return rec;
    endfunction

    // Advance the parser mirror by one item; return 1 when a record comes out
    function automatic bit frame_parse_step(input logic cmd, input logic [7:0] b,
                                            output frame_record_t rec);
        bit produced;
        bit closed;
        produced = 1'b0;
        closed   = 1'b0;
        rec      = NO_RECORD;
        if (cmd == asfr_pkg::CMD_TICK) begin
            tick_total = tick_total + 8'd1;
            if (tick_total == timeout_reg) begin
                tick_total = '0;
                rx_phase   = asfr_pkg::PHASE_IDLE;
                rx_count   = '0;
            end
            return 1'b0;
        end
        // Deliver payload, or consume the frame end byte
        if (rx_phase == asfr_pkg::PHASE_PAYLOAD) begin
            if (rx_count < declared_len) begin
                rec      = frame_fields(asfr_pkg::KIND_PAYLOAD, rx_count, b);
                produced = 1'b1;
                rx_count = rx_count + 16'd1;
            end else begin
                rx_phase = asfr_pkg::PHASE_IDLE;
                closed   = 1'b1;
            end
        end
        if (rx_phase == asfr_pkg::PHASE_IDLE && !closed && b == asfr_pkg::START_BYTE) begin
            rx_phase = asfr_pkg::PHASE_HEADER;
            rx_count = '0;
        end
        // Store header bytes, skipping start bytes
        if (rx_phase == asfr_pkg::PHASE_HEADER && b != asfr_pkg::START_BYTE &&
            rx_count < asfr_pkg::HEADER_LEN) begin
            hdr_bytes[rx_count[2:0]] = b;
            rx_count = rx_count + 16'd1;
        end
        // Accept or drop the frame on its address
        if (rx_phase == asfr_pkg::PHASE_HEADER && rx_count == asfr_pkg::HEADER_LEN) begin
            if (hdr_bytes[0] == node_addr_reg || hdr_bytes[0] == asfr_pkg::BROADCAST_ADDR) begin
                declared_len = {hdr_bytes[4], hdr_bytes[3]};
                rx_phase     = asfr_pkg::PHASE_PAYLOAD;
            end else begin
                rx_phase = asfr_pkg::PHASE_IDLE;
            end
            rx_count = '0;
        end
        if (closed) begin
            rec      = frame_fields(asfr_pkg::KIND_DONE, 16'd0, 8'd0);
            produced = 1'b1;
        end
        return produced;
    endfunction

    // Drive one item in a burst of random length; predict it once transferred
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic typed,
                             input frame_record_t want);
        int gap;
        frame_record_t rec;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (frame_parse_step(cmd, b, rec) && !typed)
            pending_records.push_back(rec);
        if (typed)
            pending_records.push_back(want);
        items_sent++;
        burst_left--;
    endtask

    // Hold the sender until every record is out, then let the pipeline settle
    task automatic drain_records();
        s_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Tick until the parser is idle, so register writes land between frames
    task automatic flush_to_idle();
        while (rx_phase != asfr_pkg::PHASE_IDLE)
            send_item(asfr_pkg::CMD_TICK, 8'($urandom), 1'b0, NO_RECORD);
    endtask

    task automatic write_config(input logic [7:0] node, input logic [7:0] tmo);
        cfg_valid <= 1'b1;
        cfg_index <= asfr_pkg::REG_NODE_ADDRESS;
        cfg_data  <= node;
        do @(posedge aclk); while (!cfg_ready);
        node_addr_reg = node;
        cfg_index <= asfr_pkg::REG_TIMEOUT_TICKS;
        cfg_data  <= tmo;
        do @(posedge aclk); while (!cfg_ready);
        timeout_reg = tmo;
        cfg_valid <= 1'b0;
    endtask

    // Build one frame with random content; a broken one is cut short
    task automatic send_frame(input bit complete);
        logic [7:0]  hdr [5];
        logic [15:0] len;
        logic [8:0]  seq [$];
        int          pick;
        int          body;
        int          cut;
        pick   = $urandom_range(0, 9);
        hdr[0] = (pick < 4) ? node_addr_reg :
                 (pick < 7) ? asfr_pkg::BROADCAST_ADDR : 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = 8'($urandom);
        if (!complete && $urandom_range(0, 2) == 0)
            len = 16'($urandom);
        else if ($urandom_range(0, 3) == 0)
            len = 16'($urandom_range(7, 40));
        else
            len = 16'($urandom_range(0, 6));
        hdr[3] = len[7:0];
        hdr[4] = len[15:8];
        seq.push_back({asfr_pkg::CMD_BYTE, asfr_pkg::START_BYTE});
        foreach (hdr[i]) begin
            if ($urandom_range(0, 7) == 0)
                seq.push_back({asfr_pkg::CMD_BYTE, asfr_pkg::START_BYTE});
            seq.push_back({asfr_pkg::CMD_BYTE, hdr[i]});
        end
        body = (len > 40) ? 40 : len;
        repeat (body) seq.push_back({asfr_pkg::CMD_BYTE, 8'($urandom)});
        seq.push_back({asfr_pkg::CMD_BYTE,
                       ($urandom_range(0, 3) == 0) ? asfr_pkg::START_BYTE : 8'($urandom)});
        if (!complete) begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut) void'(seq.pop_back());
        end
        foreach (seq[i]) begin
            if ($urandom_range(0, 23) == 0)
                send_item(asfr_pkg::CMD_TICK, 8'($urandom), 1'b0, NO_RECORD);
            send_item(seq[i][8], seq[i][7:0], 1'b0, NO_RECORD);
        end
    endtask

    task automatic random_traffic(input int quota);
        int first;
        int sel;
        first = items_sent;
        while (items_sent - first < quota) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                send_frame(1'b1);
            end else if (sel < 8) begin
                send_frame(1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(($urandom_range(0, 4) == 0) ? asfr_pkg::CMD_TICK
                                                          : asfr_pkg::CMD_BYTE,
                              8'($urandom), 1'b0, NO_RECORD);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stall the result channel in runs of its own
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            m_ready <= 1'b1;
            ready_run--;
        end else if (stall_run > 0) begin
            m_ready <= 1'b0;
            stall_run--;
        end else begin
            ready_run = $urandom_range(0, 24);
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 30)
                                                    : $urandom_range(0, 2);
        end
    end

    // Compare each result transfer with the oldest expected record
    always @(posedge aclk) begin
        frame_record_t rec;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %b index %h",
                         $time, m_kind, m_payload_index);
                errors++;
            end else begin
                rec = pending_records.pop_front();
                check_field("kind", 16'(rec.kind), 16'(m_kind));
                check_field("dest_address", 16'(rec.dest_address), 16'(m_dest_address));
                check_field("function_code", 16'(rec.function_code), 16'(m_function_code));
                check_field("subfunction_code", 16'(rec.subfunction_code),
                            16'(m_subfunction_code));
                check_field("payload_length", rec.payload_length, m_payload_length);
                check_field("payload_index", rec.payload_index, m_payload_index);
                check_field("payload_byte", 16'(rec.payload_byte), 16'(m_payload_byte));
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] phase_node [NUM_PHASES];
        logic [7:0] phase_tmo  [NUM_PHASES];
        phase_node = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom),
                       asfr_pkg::NODE_ADDRESS_RST};
        phase_tmo  = '{8'd255, 8'd1, 8'($urandom_range(2, 10)), 8'($urandom_range(1, 255)),
                       asfr_pkg::TIMEOUT_TICKS_RST};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table with reset register values
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].cmd, DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

        // Random phases, each under its own register setting, sharing the item budget
        for (int p = 0; p < NUM_PHASES; p++) begin
            flush_to_idle();
            drain_records();
            write_config(phase_node[p], phase_tmo[p]);
            random_traffic((TOTAL_ITEMS - items_sent) / (NUM_PHASES - p));
        end

        drain_records();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
hdl/asfr_pkg.sv
hdl/addressed_serial_frame_receiver.sv
hdl/asfr_checker.sv
tb/testbench.sv
